@@ rtl/sepmed3_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the median-of-three helper for the separable median filter.
package sepmed3_pkg;

    localparam int PixelBits     = 8;
    localparam int CfgWidthBits  = 12;
    localparam int CfgHeightBits = 13;
    localparam int ApbDataBits   = 32;
    localparam int ApbAddrBits   = 3;

    localparam logic [CfgWidthBits-1:0]  ResetWidth  = 12'd640;
    localparam logic [CfgHeightBits-1:0] ResetHeight = 13'd480;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_DRAIN = 1'b1
    } func_t;

    typedef enum logic {
        REG_PLANE_WIDTH  = 1'b0,
        REG_PLANE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef logic [PixelBits-1:0] pixel_t;
    typedef pixel_t [2:0]         win_row_t;
    typedef win_row_t [2:0]       window_t;

    // Per-word decisions made when the word is accepted.
    typedef struct packed {
        logic emit;
        logic filt;
        logic last;
        logic sel_up;
    } item_ctl_t;

    function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
        pixel_t lo;
        pixel_t hi;
        pixel_t m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

endpackage

@@ rtl/sepmed3_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sepmed3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sepmed3_med.sv @@
`timescale 1ns / 1ps
// Separable median of a 3x3 window: median of the three row medians.
module sepmed3_med (
    input  sepmed3_pkg::window_t win,
    output sepmed3_pkg::pixel_t  med
);

    import sepmed3_pkg::*;

    pixel_t row_med [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            row_med[k] = med3(win[k][0], win[k][1], win[k][2]);
        end
        med = med3(row_med[0], row_med[1], row_med[2]);
    end

endmodule

@@ rtl/sepmed3_seq.sv @@
`timescale 1ns / 1ps
// Plane size registers, raster position, owed-output count and per-word decisions.
module sepmed3_seq #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic                                   cfg_sel,
    input  logic [sepmed3_pkg::ApbDataBits-1:0]    cfg_wdata,
    input  logic                                   accept,
    input  logic                                   func,
    output logic [sepmed3_pkg::CfgWidthBits-1:0]   plane_width,
    output logic [sepmed3_pkg::CfgHeightBits-1:0]  plane_height,
    output logic [$clog2(MAX_WIDTH)-1:0]           col,
    output logic [$clog2(MAX_WIDTH)-1:0]           up_raddr,
    output logic [$clog2(MAX_WIDTH)-1:0]           mid_raddr,
    output sepmed3_pkg::item_ctl_t                 ctl
);

    import sepmed3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int WX = (WW > CfgWidthBits) ? WW : CfgWidthBits;
    localparam int CX = WW + 1;
    localparam int RB = $clog2(MAX_HEIGHT);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int HX = (HB > CfgHeightBits) ? HB : CfgHeightBits;
    localparam int QB = HB + 1;
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int ResetW = (int'(ResetWidth) > MAX_WIDTH) ? MAX_WIDTH : int'(ResetWidth);
    localparam int ResetH = (int'(ResetHeight) > MAX_HEIGHT) ? MAX_HEIGHT : int'(ResetHeight);

    logic [CfgWidthBits-1:0]  plane_width_reg, plane_width_next;
    logic [CfgHeightBits-1:0] plane_height_reg, plane_height_next;
    logic [WW-1:0]            w_reg, w_next;
    logic [HB-1:0]            h_reg, h_next;
    logic [CW-1:0]            col_reg, col_next;
    logic [RB-1:0]            row_reg, row_next;
    logic [PW-1:0]            pending_reg, pending_next;

    logic [WX-1:0] pw_x, w_clamp;
    logic [HX-1:0] ph_x, h_clamp;
    logic [WW-1:0] wm1_full;
    logic [CW-1:0] wm1;
    logic [PW-1:0] wp1, dmid_full;
    logic [CW-1:0] qc;
    logic [1:0]    k;
    logic [QB-1:0] r_x, h_x, k_x, qr_x;
    logic          is_drain, pend_full, drain_ok, col_last, row_last, filt, last_pos;

    // Size registers and their clamped working values.
    always_comb
    begin
        plane_width_next  = plane_width_reg;
        plane_height_next = plane_height_reg;
        if (cfg_we && (cfg_sel == REG_PLANE_WIDTH))
        begin
            plane_width_next = cfg_wdata[CfgWidthBits-1:0];
        end
        if (cfg_we && (cfg_sel == REG_PLANE_HEIGHT))
        begin
            plane_height_next = cfg_wdata[CfgHeightBits-1:0];
        end

        pw_x = WX'(plane_width_next);
        if (pw_x == '0)
        begin
            w_clamp = WX'(1);
        end
        else if (pw_x > WX'(MAX_WIDTH))
        begin
            w_clamp = WX'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = pw_x;
        end
        w_next = w_clamp[WW-1:0];

        ph_x = HX'(plane_height_next);
        if (ph_x == '0)
        begin
            h_clamp = HX'(1);
        end
        else if (ph_x > HX'(MAX_HEIGHT))
        begin
            h_clamp = HX'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = ph_x;
        end
        h_next = h_clamp[HB-1:0];
    end

    // Decisions for the word at the input.
    always_comb
    begin
        is_drain  = (func == FUNC_DRAIN);
        wm1_full  = w_reg - WW'(1);
        wm1       = wm1_full[CW-1:0];
        wp1       = PW'(w_reg) + PW'(1);
        dmid_full = PW'(w_reg) - pending_reg;
        pend_full = (pending_reg >= wp1);
        drain_ok  = (col_reg == '0) && (row_reg == '0) && (pending_reg != '0)
                    && (pending_reg <= wp1);
        col_last  = ((WW'(col_reg) + WW'(1)) == w_reg);
        row_last  = ((HB'(row_reg) + HB'(1)) == h_reg);

        // The emitted pixel sits one row and one column behind the input.
        if (col_reg == '0)
        begin
            qc = wm1;
            k  = 2'd2;
        end
        else
        begin
            qc = col_reg - CW'(1);
            k  = 2'd1;
        end
        r_x = QB'(row_reg);
        h_x = QB'(h_reg);
        k_x = QB'(k);
        if (h_reg == HB'(1))
        begin
            qr_x = '0;
        end
        else if (r_x >= k_x)
        begin
            qr_x = r_x - k_x;
        end
        else
        begin
            qr_x = r_x + h_x - k_x;
        end

        filt     = (qr_x >= QB'(2)) && ((qr_x + QB'(3)) <= h_x)
                   && (qc >= CW'(1)) && ((CX'(qc) + CX'(2)) <= CX'(w_reg));
        last_pos = (qr_x == (h_x - QB'(1))) && (qc == wm1);

        if (is_drain)
        begin
            ctl.emit   = drain_ok;
            ctl.filt   = 1'b0;
            ctl.last   = (pending_reg == PW'(1));
            ctl.sel_up = (pending_reg == wp1);
            up_raddr   = wm1;
            mid_raddr  = dmid_full[CW-1:0];
        end
        else
        begin
            ctl.emit   = pend_full;
            ctl.filt   = filt;
            ctl.last   = last_pos;
            ctl.sel_up = 1'b0;
            up_raddr   = col_reg;
            mid_raddr  = col_reg;
        end
    end

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        pending_next = pending_reg;
        if (cfg_we)
        begin
            col_next     = '0;
            row_next     = '0;
            pending_next = '0;
        end
        else if (accept && !is_drain)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : (row_reg + RB'(1));
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
            pending_next = pend_full ? wp1 : (pending_reg + PW'(1));
        end
        else if (accept && drain_ok)
        begin
            pending_next = pending_reg - PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_width_reg  <= ResetWidth;
            plane_height_reg <= ResetHeight;
            w_reg            <= WW'(ResetW);
            h_reg            <= HB'(ResetH);
            col_reg          <= '0;
            row_reg          <= '0;
            pending_reg      <= '0;
        end
        else
        begin
            plane_width_reg  <= plane_width_next;
            plane_height_reg <= plane_height_next;
            w_reg            <= w_next;
            h_reg            <= h_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            pending_reg      <= pending_next;
        end
    end

    assign plane_width  = plane_width_reg;
    assign plane_height = plane_height_reg;
    assign col          = col_reg;

endmodule

@@ rtl/separable_median3x3_filter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the separable 3x3 median filter over one 8-bit plane.
//
// Source words (func, in_pixel) enter on src_valid/src_ready in raster order; result
// words (out_pixel, last_of_frame) leave on dst_valid/dst_ready. A pixel word is
// pushed with func low; a drain word (func high) between frames returns one owed
// output. Results lag the pixel stream by plane_width+1 pixels, so the first
// plane_width+1 pixels after reset or a register write give no word.
// Stage 1 holds an accepted word with its registered line-buffer reads, and the output
// register then takes its result. Throughput is one word per cycle unless the output
// stalls, set by the one read port of each line buffer. plane_width (address 0) and
// plane_height (address 4) are written over the APB port; the user must write them
// only while the block is idle, which the block itself does not enforce. A write
// restarts the frame and drops owed outputs. Reset restores 640x480 and clears
// position and window; the line buffers are not cleared, and hold unknown data until
// the first two rows have passed. When dst_ready is low the output register holds
// its word. Words that give no result still pass through; the next word that gives
// one waits in stage 1, and src_ready stays low until the output register frees.
module separable_median3x3_filter_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sepmed3_pkg::ApbAddrBits-1:0]  paddr,
    input  logic [sepmed3_pkg::ApbDataBits-1:0]  pwdata,
    output logic [sepmed3_pkg::ApbDataBits-1:0]  prdata,
    output logic                                 pready,
    input  logic                                 src_valid,
    output logic                                 src_ready,
    input  logic                                 func,
    input  sepmed3_pkg::pixel_t                  in_pixel,
    output logic                                 dst_valid,
    input  logic                                 dst_ready,
    output sepmed3_pkg::pixel_t                  out_pixel,
    output logic                                 last_of_frame
);

    import sepmed3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic                     cfg_we;
    logic                     cfg_sel;
    logic [CfgWidthBits-1:0]  plane_width;
    logic [CfgHeightBits-1:0] plane_height;
    logic [CW-1:0]            col, up_raddr, mid_raddr;
    item_ctl_t                ctl;
    logic                     accept;

    logic      s1_valid_reg;
    logic      s1_func_reg;
    item_ctl_t s1_ctl_reg;
    pixel_t    s1_px_reg;
    logic [CW-1:0] s1_col_reg;
    logic      fwd_up_reg, fwd_mid_reg;
    pixel_t    fwd_up_data_reg, fwd_mid_data_reg;
    logic      fwd_up_next, fwd_mid_next;

    window_t win_reg, win_next;
    pixel_t  up_rdata, mid_rdata, up_v, mid_v, med, result;
    logic    s1_free, s1_move, s1_wr;

    logic   dst_valid_reg;
    pixel_t out_pixel_reg;
    logic   last_reg;

    // Configuration port.
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_sel = paddr[ApbAddrBits-1];
    assign pready  = 1'b1;

    always_comb
    begin
        case (reg_idx_t'(paddr[ApbAddrBits-1]))
            REG_PLANE_WIDTH:  prdata = ApbDataBits'(plane_width);
            REG_PLANE_HEIGHT: prdata = ApbDataBits'(plane_height);
            default:          prdata = '0;
        endcase
    end

    sepmed3_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_sel      (cfg_sel),
        .cfg_wdata    (pwdata),
        .accept       (accept),
        .func         (func),
        .plane_width  (plane_width),
        .plane_height (plane_height),
        .col          (col),
        .up_raddr     (up_raddr),
        .mid_raddr    (mid_raddr),
        .ctl          (ctl)
    );

    // Handshake: stage 1 only blocks when it holds a result the output cannot take.
    assign s1_free   = !s1_valid_reg || !s1_ctl_reg.emit || !dst_valid_reg || dst_ready;
    assign src_ready = s1_free;
    assign accept    = src_valid && src_ready;
    assign s1_move   = s1_valid_reg && s1_free;
    assign s1_wr     = s1_move && (s1_func_reg == FUNC_PIXEL);

    // The line buffers hold the rows two above and one above the input.
    sepmed3_ram #(
        .WIDTH (PixelBits),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (s1_wr),
        .waddr (s1_col_reg),
        .wdata (mid_v),
        .re    (accept),
        .raddr (up_raddr),
        .rdata (up_rdata)
    );

    sepmed3_ram #(
        .WIDTH (PixelBits),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk   (clk),
        .we    (s1_wr),
        .waddr (s1_col_reg),
        .wdata (s1_px_reg),
        .re    (accept),
        .raddr (mid_raddr),
        .rdata (mid_rdata)
    );

    // A read that hits the address written in the same cycle takes the new data.
    assign fwd_up_next  = s1_wr && (s1_col_reg == up_raddr);
    assign fwd_mid_next = s1_wr && (s1_col_reg == mid_raddr);
    assign up_v  = fwd_up_reg  ? fwd_up_data_reg  : up_rdata;
    assign mid_v = fwd_mid_reg ? fwd_mid_data_reg : mid_rdata;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = up_v;
        win_next[1][2] = mid_v;
        win_next[2][2] = s1_px_reg;
    end

    sepmed3_med u_med (
        .win (win_next),
        .med (med)
    );

    always_comb
    begin
        if (s1_func_reg == FUNC_DRAIN)
        begin
            result = s1_ctl_reg.sel_up ? up_v : mid_v;
        end
        else
        begin
            result = s1_ctl_reg.filt ? med : win_next[1][1];
        end
    end

    // Stage 1 payload and output register data.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg      <= func;
            s1_ctl_reg       <= ctl;
            s1_px_reg        <= in_pixel;
            s1_col_reg       <= col;
            fwd_up_reg       <= fwd_up_next;
            fwd_mid_reg      <= fwd_mid_next;
            fwd_up_data_reg  <= mid_v;
            fwd_mid_data_reg <= s1_px_reg;
        end
        if (s1_move && s1_ctl_reg.emit)
        begin
            out_pixel_reg <= result;
            last_reg      <= s1_ctl_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            dst_valid_reg <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move && s1_ctl_reg.emit)
            begin
                dst_valid_reg <= 1'b1;
            end
            else if (dst_ready)
            begin
                dst_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                win_reg <= '0;
            end
            else if (s1_wr)
            begin
                win_reg <= win_next;
            end
        end
    end

    assign dst_valid     = dst_valid_reg;
    assign out_pixel     = out_pixel_reg;
    assign last_of_frame = last_reg;

    // A new word never lands on a stage-1 word that is not leaving.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!s1_valid_reg || s1_move))
        else $error("stage 1 word overwritten");

    // A result leaving stage 1 is in the output register on the next cycle.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_ctl_reg.emit) |=> dst_valid_reg)
        else $error("result lost between stage 1 and output");

    // Drain words only return stored pixels, never a filtered value.
    a_drain_unfiltered: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_DRAIN)) |=> (s1_valid_reg && !s1_ctl_reg.filt))
        else $error("drain word marked for filtering");

endmodule

@@ dv/separable_median3x3_filter_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the separable 3x3 median filter unit.
module separable_median3x3_filter_unit_test;
    import sepmed3_pkg::*;

    localparam int LineMax      = 2048;
    localparam int RowMax       = 4096;
    localparam int RegStride    = 4;
    localparam int StallLimit   = 3000;
    localparam int LongHold     = 400;
    localparam int SettleCycles = 6;
    localparam int RandomPixels = 1500;

    typedef struct packed {
        func_t  f;
        pixel_t px;
    } src_word_t;

    typedef struct packed {
        pixel_t px;
        logic   last;
    } filt_result_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [ApbAddrBits-1:0] paddr         = '0;
    logic [ApbDataBits-1:0] pwdata        = '0;
    logic [ApbDataBits-1:0] prdata;
    logic                   pready;
    logic                   src_valid     = 1'b0;
    logic                   src_ready;
    logic                   func          = FUNC_PIXEL;
    pixel_t                 in_pixel      = '0;
    logic                   dst_valid;
    logic                   dst_ready     = 1'b0;
    pixel_t                 out_pixel;
    logic                   last_of_frame;

    src_word_t    src_words[$];
    filt_result_t due_pixels[$];
    int           words_in_flight = 0;
    int           mismatches      = 0;
    int           random_pixels   = 0;
    int           src_gap         = 0;
    int           dst_stall       = 0;
    int           quiet           = 0;
    bit           src_taken       = 1'b0;
    bit           src_calm        = 1'b0;
    bit           dst_calm        = 1'b0;
    bit           hold_req        = 1'b0;

    // Predictor state: the configuration, line buffers, window, position and owed count.
    logic [CfgWidthBits-1:0]  plane_w_reg;
    logic [CfgHeightBits-1:0] plane_h_reg;
    pixel_t                   line_up[LineMax];
    pixel_t                   line_mid[LineMax];
    pixel_t                   win[3][3];
    int unsigned              at_col;
    int unsigned              at_row;
    int unsigned              owed;

    separable_median3x3_filter_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .src_valid     (src_valid),
        .src_ready     (src_ready),
        .func          (func),
        .in_pixel      (in_pixel),
        .dst_valid     (dst_valid),
        .dst_ready     (dst_ready),
        .out_pixel     (out_pixel),
        .last_of_frame (last_of_frame)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    function automatic int unsigned eff_w();
        if (plane_w_reg < 1) return 1;
        if (plane_w_reg > LineMax) return LineMax;
        return int'(plane_w_reg);
    endfunction

    function automatic int unsigned eff_h();
        if (plane_h_reg < 1) return 1;
        if (plane_h_reg > RowMax) return RowMax;
        return int'(plane_h_reg);
    endfunction

    function automatic pixel_t mid_of3(input pixel_t a, input pixel_t b, input pixel_t c);
        int mx;
        int mn;
        mx = (a > b) ? ((a > c) ? a : c) : ((b > c) ? b : c);
        mn = (a < b) ? ((a < c) ? a : c) : ((b < c) ? b : c);
        return pixel_t'(int'(a) + int'(b) + int'(c) - mx - mn);
    endfunction

    function automatic pixel_t rand_pixel();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return pixel_t'($urandom_range(0, 255));
    endfunction

    function automatic int gap_len(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic restart_frame();
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                win[i][j] = '0;
            end
        end
        at_col = 0;
        at_row = 0;
        owed   = 0;
    endtask

    task automatic plane_reg_write(input reg_idx_t idx, input logic [ApbDataBits-1:0] data);
        if (idx == REG_PLANE_WIDTH)
            plane_w_reg = data[CfgWidthBits-1:0];
        else
            plane_h_reg = data[CfgHeightBits-1:0];
        restart_frame();
    endtask

    // Works out the result, if any, of one accepted word and queues it.
    task automatic median_predict(input func_t f, input pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned area;
        int unsigned q;
        int unsigned qr;
        int unsigned qc;
        pixel_t      v;
        pixel_t      mid_old;
        w    = eff_w();
        h    = eff_h();
        area = w * h;
        if (f == FUNC_DRAIN)
        begin
            // Only a drain at a frame boundary with outputs owed returns a word.
            if (at_col == 0 && at_row == 0 && owed != 0 && owed <= w + 1)
            begin
                v = (owed == w + 1) ? line_up[w-1] : line_mid[w-owed];
                due_pixels.push_back(filt_result_t'{v, owed == 1});
                owed--;
            end
        end
        else
        begin
            mid_old = line_mid[at_col];
            for (int k = 0; k < 3; k++)
            begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2]        = line_up[at_col];
            win[1][2]        = mid_old;
            win[2][2]        = px;
            line_up[at_col]  = mid_old;
            line_mid[at_col] = px;
            owed++;
            if (owed > w + 1)
            begin
                owed = w + 1;
                q    = (at_row * w + at_col + 2 * area - w - 1) % area;
                qr   = q / w;
                qc   = q % w;
                if (qr >= 2 && qr + 3 <= h && qc >= 1 && qc + 2 <= w)
                    v = mid_of3(mid_of3(win[0][0], win[0][1], win[0][2]),
                                mid_of3(win[1][0], win[1][1], win[1][2]),
                                mid_of3(win[2][0], win[2][1], win[2][2]));
                else
                    v = win[1][1];
                due_pixels.push_back(filt_result_t'{v, q == area - 1});
            end
            at_col++;
            if (at_col >= w)
            begin
                at_col = 0;
                at_row++;
                if (at_row >= h) at_row = 0;
            end
        end
    endtask

    task automatic push_word(input func_t f, input pixel_t px);
        src_words.push_back(src_word_t'{f, px});
        words_in_flight++;
    endtask

    // Waits until every word is taken and every result is in, then lets the pipe empty.
    task automatic settle();
        while (words_in_flight != 0 || due_pixels.size() != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int unsigned value);
        logic [ApbDataBits-1:0] data;
        data = $urandom;
        if (idx == REG_PLANE_WIDTH)
            data[CfgWidthBits-1:0] = value[CfgWidthBits-1:0];
        else
            data[CfgHeightBits-1:0] = value[CfgHeightBits-1:0];
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ApbAddrBits'(int'(idx) * RegStride);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        plane_reg_write(idx, data);
    endtask

    task automatic read_reg(input reg_idx_t idx, input int unsigned want);
        logic [ApbDataBits-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= ApbAddrBits'(int'(idx) * RegStride);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== ApbDataBits'(want))
            report_mismatch($sformatf("%s reads %0d, wrote %0d", idx.name(), got, want));
    endtask

    task automatic set_plane(input int unsigned w_raw, input int unsigned h_raw);
        settle();
        src_calm = ($urandom_range(0, 3) == 0);
        dst_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1) == 0)
        begin
            write_reg(REG_PLANE_WIDTH, w_raw);
            write_reg(REG_PLANE_HEIGHT, h_raw);
        end
        else
        begin
            write_reg(REG_PLANE_HEIGHT, h_raw);
            write_reg(REG_PLANE_WIDTH, w_raw);
        end
        read_reg(REG_PLANE_WIDTH, w_raw & ((1 << CfgWidthBits) - 1));
        read_reg(REG_PLANE_HEIGHT, h_raw & ((1 << CfgHeightBits) - 1));
    endtask

    // Whole frames of random content with stray drains, drains of random count at each
    // frame boundary, and now and then a last frame that is cut short.
    task automatic push_frames(input int nframes);
        int unsigned w;
        int unsigned h;
        int unsigned area;
        int unsigned cut;
        int unsigned ndrain;
        int unsigned r;
        w    = eff_w();
        h    = eff_h();
        area = w * h;
        if ($urandom_range(0, 9) == 0) push_word(FUNC_DRAIN, rand_pixel());
        for (int f = 0; f < nframes; f++)
        begin
            cut = area;
            if (f == nframes - 1 && $urandom_range(0, 9) == 0) cut = $urandom_range(1, area);
            for (int unsigned k = 0; k < cut; k++)
            begin
                push_word(FUNC_PIXEL, rand_pixel());
                random_pixels++;
                if (k + 1 < area && $urandom_range(0, 24) == 0)
                    push_word(FUNC_DRAIN, rand_pixel());
            end
            if (cut == area)
            begin
                r      = $urandom_range(0, 9);
                ndrain = (r < 5) ? w + 1 : ((r < 8) ? $urandom_range(0, w) : 0);
                repeat (ndrain) push_word(FUNC_DRAIN, rand_pixel());
            end
        end
    endtask

    always @(posedge clk)
    begin : src_monitor
        if (rst_n && src_valid && src_ready)
        begin
            median_predict(func_t'(func), in_pixel);
            words_in_flight--;
            src_taken = 1'b1;
        end
    end

    always @(posedge clk)
    begin : dst_monitor
        filt_result_t head;
        if (rst_n && dst_valid && dst_ready)
        begin
            if (due_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word: pixel %0d last %0b",
                                          out_pixel, last_of_frame));
            end
            else
            begin
                head = due_pixels.pop_front();
                // A pixel taken from a line-buffer entry never written has no set value.
                if (!$isunknown(head.px) && out_pixel !== head.px)
                    report_mismatch($sformatf("out_pixel %0d, predicted %0d",
                                              out_pixel, head.px));
                if (last_of_frame !== head.last)
                    report_mismatch($sformatf("last_of_frame %0b, predicted %0b",
                                              last_of_frame, head.last));
            end
        end
    end

    always @(negedge clk)
    begin : src_driver
        src_word_t word;
        if (rst_n && (!src_valid || src_taken))
        begin
            src_taken = 1'b0;
            if (src_gap > 0)
            begin
                src_gap--;
                src_valid <= 1'b0;
            end
            else if (src_words.size() > 0)
            begin
                word = src_words.pop_front();
                func      <= word.f;
                in_pixel  <= word.px;
                src_valid <= 1'b1;
                src_gap   = gap_len(src_calm);
            end
            else
            begin
                src_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : dst_driver
        if (rst_n)
        begin
            if (dst_stall > 0)
            begin
                dst_stall--;
                dst_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                // A long hold-off so that the block fills up and stalls its input.
                hold_req  = 1'b0;
                dst_stall = LongHold - 1;
                dst_ready <= 1'b0;
            end
            else
            begin
                dst_ready <= 1'b1;
                dst_stall = gap_len(dst_calm);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((src_valid && src_ready) || (dst_valid && dst_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
                if (quiet >= StallLimit)
                begin
                    $display("watchdog: %0d cycles without a word moving", quiet);
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        pixel_t      demo[15];
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned r;
        int          nframes;
        // Rows of a 3x5 plane; the one filtered position differs from its center pixel.
        demo = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd200, 8'd0, 8'd255, 8'd40,
                 8'd30, 8'd0, 8'd0, 8'd128, 8'd1, 8'd254};
        plane_w_reg = ResetWidth;
        plane_h_reg = ResetHeight;
        // The line buffers come out of reset with no defined contents.
        for (int i = 0; i < LineMax; i++)
        begin
            line_up[i]  = 'x;
            line_mid[i] = 'x;
        end
        restart_frame();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        read_reg(REG_PLANE_WIDTH, ResetWidth);
        read_reg(REG_PLANE_HEIGHT, ResetHeight);

        // Directed: a drain with nothing owed, a full frame with a stray drain inside it,
        // a partial drain at the boundary, then pixels of the next frame.
        set_plane(3, 5);
        push_word(FUNC_DRAIN, 8'd0);
        for (int i = 0; i < 15; i++)
        begin
            push_word(FUNC_PIXEL, demo[i]);
            if (i == 6) push_word(FUNC_DRAIN, 8'd255);
        end
        push_word(FUNC_DRAIN, 8'd0);
        push_word(FUNC_DRAIN, 8'd255);
        repeat (4) push_word(FUNC_PIXEL, rand_pixel());

        set_plane(5, 6);
        hold_req = 1'b1;
        push_frames(2);

        // Widest plane, width above the limit; results start after a full row and one pixel.
        set_plane(4095, 4096);
        repeat (LineMax + 40) push_word(FUNC_PIXEL, rand_pixel());

        set_plane(1, 8191);
        repeat (12) push_word(FUNC_PIXEL, rand_pixel());
        push_word(FUNC_DRAIN, rand_pixel());

        set_plane(0, 0);
        push_frames(4);

        while (random_pixels < RandomPixels)
        begin
            r     = $urandom_range(0, 99);
            w_raw = (r < 5) ? 0 : ((r < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40));
            r     = $urandom_range(0, 99);
            h_raw = (r < 5) ? 0 : ((r < 80) ? $urandom_range(1, 8) : $urandom_range(9, 12));
            set_plane(w_raw, h_raw);
            nframes = (eff_w() * eff_h() > 64) ? 1 : $urandom_range(1, 4);
            push_frames(nframes);
        end

        settle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
